### sv/rfwm_pkg.sv
// shared types and constants of the reverse flow window matcher
package rfwm_pkg;

    localparam int TIME_W      = 48;
    localparam int ADDR_W      = 32;
    localparam int IVL_W       = 32;
    localparam int ENTRY_W     = TIME_W + 2 * ADDR_W;
    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 8;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic issue;
        logic commit;
    } rfwm_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic empty;
        logic issue_last;
        logic out_free;
    } rfwm_status_t;

endpackage

### sv/rfwm_ram.sv
// generic single write port ram with registered read
module rfwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/rfwm_ctrl.sv
// controller state machine of the reverse flow window matcher
module rfwm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  rfwm_pkg::rfwm_status_t status,
    output rfwm_pkg::rfwm_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.empty ? ST_COMMIT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (status.issue_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/rfwm_datapath.sv
// window store, scan, eviction and result register of the matcher
module rfwm_datapath #(
    parameter int WINDOW_DEPTH = 256
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  rfwm_pkg::rfwm_cmd_t                   cmd,
    output rfwm_pkg::rfwm_status_t                status,
    input  logic [rfwm_pkg::IN_TDATA_W-1:0]       s_tdata,
    input  logic                                  cfg_valid,
    input  logic [rfwm_pkg::IVL_W-1:0]            cfg_data,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [rfwm_pkg::OUT_TDATA_W-1:0]      m_tdata
);

    localparam int PTR_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int TW    = rfwm_pkg::TIME_W;
    localparam int AW    = rfwm_pkg::ADDR_W;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

    logic [rfwm_pkg::IVL_W-1:0] ivl_reg;
    logic [PTR_W-1:0]           head_reg, head_next;
    logic [PTR_W-1:0]           tail_reg, tail_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [PTR_W-1:0]           rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]           left_reg, left_next;
    logic                       cmp_valid_reg, cmp_valid_next;
    logic [PTR_W-1:0]           ehead_reg, ehead_next;
    logic [CNT_W-1:0]           ecount_reg, ecount_next;
    logic                       evicting_reg, evicting_next;
    logic                       first_reg, first_next;
    logic                       paired_reg, paired_next;
    logic                       m_valid_reg, m_valid_next;
    logic                       m_pair_reg, m_pair_next;

    logic [TW-1:0] now_reg;
    logic [AW-1:0] src_reg;
    logic [AW-1:0] dst_reg;

    logic [rfwm_pkg::ENTRY_W-1:0] rd_data;
    logic [rfwm_pkg::ENTRY_W-1:0] wr_data;
    logic [TW-1:0]                 e_time;
    logic [AW-1:0]                 e_src;
    logic [AW-1:0]                 e_dst;
    logic [TW:0]                   age;
    logic                          age_neg;
    logic                          in_ivl;
    logic                          younger;
    logic                          drop;
    logic                          win_full;

    rfwm_ram #(
        .WIDTH (rfwm_pkg::ENTRY_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.commit),
        .waddr (tail_reg),
        .wdata (wr_data),
        .raddr (rd_ptr_reg),
        .rdata (rd_data)
    );

    // entry layout: time lowest, then source, then destination
    assign wr_data = {dst_reg, src_reg, now_reg};
    assign e_time  = rd_data[TW-1:0];
    assign e_src   = rd_data[TW+AW-1:TW];
    assign e_dst   = rd_data[TW+2*AW-1:TW+AW];

    // age of the entry, negative when time runs backwards
    assign age     = {1'b0, now_reg} - {1'b0, e_time};
    assign age_neg = age[TW];
    assign in_ivl  = age_neg || (age[TW-1:0] <= TW'(ivl_reg));
    assign younger = age_neg || (age[TW-1:0] < TW'(ivl_reg));

    assign drop     = first_reg ? !in_ivl : (evicting_reg && !younger);
    assign win_full = (ecount_reg == CNT_W'(WINDOW_DEPTH));

    assign status.empty      = (count_reg == '0);
    assign status.issue_last = (left_reg == CNT_W'(1));
    assign status.out_free   = !m_valid_reg || m_tready;

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        rd_ptr_next    = rd_ptr_reg;
        left_next      = left_reg;
        cmp_valid_next = 1'b0;
        ehead_next     = ehead_reg;
        ecount_next    = ecount_reg;
        evicting_next  = evicting_reg;
        first_next     = first_reg;
        paired_next    = paired_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_pair_next    = m_pair_reg;

        if (cmd.load)
        begin
            rd_ptr_next   = head_reg;
            left_next     = count_reg;
            ehead_next    = head_reg;
            ecount_next   = count_reg;
            evicting_next = 1'b1;
            first_next    = 1'b1;
            paired_next   = 1'b0;
        end

        if (cmd.issue && (left_reg != '0))
        begin
            rd_ptr_next    = ptr_inc(rd_ptr_reg);
            left_next      = left_reg - CNT_W'(1);
            cmp_valid_next = 1'b1;
        end

        if (cmp_valid_reg)
        begin
            first_next = 1'b0;
            if (e_dst == src_reg && e_src == dst_reg && in_ivl)
            begin
                paired_next = 1'b1;
            end
            if (drop)
            begin
                ehead_next  = ptr_inc(ehead_reg);
                ecount_next = ecount_reg - CNT_W'(1);
            end
            else
            begin
                evicting_next = 1'b0;
            end
        end

        if (cmd.commit)
        begin
            tail_next = ptr_inc(tail_reg);
            if (win_full)
            begin
                // oldest entry gives way to the new one
                head_next  = ptr_inc(ehead_reg);
                count_next = ecount_reg;
            end
            else
            begin
                head_next  = ehead_reg;
                count_next = ecount_reg + CNT_W'(1);
            end
            m_valid_next = 1'b1;
            m_pair_next  = paired_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivl_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            rd_ptr_reg    <= '0;
            left_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            ehead_reg     <= '0;
            ecount_reg    <= '0;
            evicting_reg  <= 1'b0;
            first_reg     <= 1'b0;
            paired_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
            m_pair_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                ivl_reg <= cfg_data;
            end
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            rd_ptr_reg    <= rd_ptr_next;
            left_reg      <= left_next;
            cmp_valid_reg <= cmp_valid_next;
            ehead_reg     <= ehead_next;
            ecount_reg    <= ecount_next;
            evicting_reg  <= evicting_next;
            first_reg     <= first_next;
            paired_reg    <= paired_next;
            m_valid_reg   <= m_valid_next;
            m_pair_reg    <= m_pair_next;
        end
    end

    // item fields
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg <= s_tdata[TW-1:0];
            src_reg <= s_tdata[TW+AW-1:TW];
            dst_reg <= s_tdata[TW+2*AW-1:TW+AW];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(rfwm_pkg::OUT_TDATA_W - 1)'(0), m_pair_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(WINDOW_DEPTH))
        else $error("window count above depth");

    a_ring_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == CNT_W'(WINDOW_DEPTH)) |-> head_reg == tail_reg)
        else $error("head and tail disagree with count");

    a_evict_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ecount_reg <= count_reg || cmd.load)
        else $error("eviction past the window");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!m_valid_reg || m_tready))
        else $error("result overwritten before taken");

    a_scan_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (left_reg == '0 && !cmp_valid_reg))
        else $error("commit before scan finished");

endmodule

### sv/reverse_flow_window_matcher_top.sv
// top level of the reverse flow window matcher
//
// channel   dir  handshake            payload
// s_*       in   s_tvalid/s_tready    arrival_time, source_addr, dest_addr
// m_*       out  m_tvalid/m_tready    pair_seen
// cfg_*     in   cfg_valid/cfg_ready  match_interval
//
// an item is loaded, scanned and committed before the next; empty windows skip scan
// the single ram read port scans one window entry a cycle
// reset empties the window at once and clears the interval to zero
// a result waits in the output register while the next item is scanned
// the commit of an item holds while the previous result is not taken
module reverse_flow_window_matcher_top #(
    parameter int WINDOW_DEPTH = 256
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // arrival_time [47:0], source_addr [79:48], dest_addr [111:80]
    input  logic [rfwm_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // pair_seen [0], zero fill [7:1]
    output logic [rfwm_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rfwm_pkg::IVL_W-1:0]           cfg_data
);

    rfwm_pkg::rfwm_cmd_t    cmd;
    rfwm_pkg::rfwm_status_t status;

    assign cfg_ready = 1'b1;

    rfwm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rfwm_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

### tb/sv/reverse_flow_window_matcher_top_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the reverse flow window matcher top level
module reverse_flow_window_matcher_top_tb;

    localparam int TIME_W      = rfwm_pkg::TIME_W;
    localparam int ADDR_W      = rfwm_pkg::ADDR_W;
    localparam int IVL_W       = rfwm_pkg::IVL_W;
    localparam int IN_TDATA_W  = rfwm_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = rfwm_pkg::OUT_TDATA_W;

    localparam int WIN_DEPTH     = 256;
    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = WIN_DEPTH + 8;
    localparam int STALL_LIMIT   = 4000;
    localparam int PCT_HEAVY     = 76;
    localparam int PCT_BOTH      = 28;
    localparam int NUM_PHASES    = 5;
    localparam int RECENT_KEEP   = 16;

    localparam bit [TIME_W-1:0] TIME_MAX  = '1;
    localparam bit [ADDR_W-1:0] ADDR_ONES = '1;
    localparam bit [ADDR_W-1:0] HOST_A    = 32'h0A00_0001;
    localparam bit [ADDR_W-1:0] HOST_B    = 32'hC0A8_0001;
    localparam bit [ADDR_W-1:0] HOST_X    = 32'h5555_AAAA;
    localparam bit [ADDR_W-1:0] HOST_Y    = 32'hAAAA_5555;
    localparam bit [ADDR_W-1:0] HOST_Z    = 32'h8000_0001;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct {
        bit [TIME_W-1:0] stamp;
        bit [ADDR_W-1:0] src;
        bit [ADDR_W-1:0] dst;
    } flow_entry_t;

    typedef struct {
        bit              is_cfg;
        bit [IVL_W-1:0]  interval;
        bit [TIME_W-1:0] stamp;
        bit [ADDR_W-1:0] src;
        bit [ADDR_W-1:0] dst;
        bit              known;
        bit              pair;
    } probe_row_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [IVL_W-1:0]       cfg_data  = '0;

    // typed expectation travelling beside the item
    bit row_known = 1'b0;
    bit row_pair  = 1'b0;

    flow_entry_t    flow_window[$];
    bit [IVL_W-1:0] pair_interval = '0;
    bit             pair_expect_q[$];
    probe_row_t     probe_table[$];
    int             mismatch_count = 0;
    int             idle_cycles    = 0;
    int             send_idle_pct  = 0;
    int             recv_stall_pct = 0;
    int             hold_requests  = 0;
    int             hold_served    = 0;
    int             hold_left      = 0;

    reverse_flow_window_matcher_top #(
        .WINDOW_DEPTH(WIN_DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic bit age_within(input bit [TIME_W-1:0] now,
                                      input bit [TIME_W-1:0] stamp);
        bit [TIME_W-1:0] ivl_wide;
        ivl_wide = TIME_W'(pair_interval);
        if (now < stamp)
            return 1'b1;
        return (now - stamp) <= ivl_wide;
    endfunction

    function automatic bit age_younger(input bit [TIME_W-1:0] now,
                                       input bit [TIME_W-1:0] stamp);
        bit [TIME_W-1:0] ivl_wide;
        ivl_wide = TIME_W'(pair_interval);
        if (now < stamp)
            return 1'b1;
        return (now - stamp) < ivl_wide;
    endfunction

    // match against the window, then evict and push the new packet
    function automatic bit predict_reverse_pair(input bit [TIME_W-1:0] now,
                                                input bit [ADDR_W-1:0] src,
                                                input bit [ADDR_W-1:0] dst);
        bit          paired;
        flow_entry_t fresh;
        paired = 1'b0;
        foreach (flow_window[k])
        begin
            if (flow_window[k].src == dst && flow_window[k].dst == src &&
                age_within(now, flow_window[k].stamp))
                paired = 1'b1;
        end
        if (flow_window.size() != 0 && !age_within(now, flow_window[0].stamp))
        begin
            flow_window.delete(0);
            while (flow_window.size() != 0 && !age_younger(now, flow_window[0].stamp))
                flow_window.delete(0);
        end
        if (flow_window.size() >= WIN_DEPTH)
            flow_window.delete(0);
        fresh.stamp = now;
        fresh.src   = src;
        fresh.dst   = dst;
        flow_window.insert(flow_window.size(), fresh);
        return paired;
    endfunction

    function automatic void add_row(input bit is_cfg, input bit [IVL_W-1:0] interval,
                                    input bit [TIME_W-1:0] stamp,
                                    input bit [ADDR_W-1:0] src, input bit [ADDR_W-1:0] dst,
                                    input bit known, input bit pair);
        probe_row_t row;
        row.is_cfg   = is_cfg;
        row.interval = interval;
        row.stamp    = stamp;
        row.src      = src;
        row.dst      = dst;
        row.known    = known;
        row.pair     = pair;
        probe_table.insert(probe_table.size(), row);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= 200)
            $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic set_idle_mode(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER:
            begin
                send_idle_pct = PCT_HEAVY;
                recv_stall_pct <= 0;
            end
            IDLE_RECEIVER:
            begin
                send_idle_pct = 0;
                recv_stall_pct <= PCT_HEAVY;
            end
            IDLE_BOTH:
            begin
                send_idle_pct = PCT_BOTH;
                recv_stall_pct <= PCT_BOTH;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_stall_pct <= 0;
            end
        endcase
    endtask

    task automatic send_item(input bit [TIME_W-1:0] stamp, input bit [ADDR_W-1:0] src,
                             input bit [ADDR_W-1:0] dst, input bit known, input bit pair);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= {dst, src, stamp};
        row_known <= known;
        row_pair  <= pair;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // stop offering items until every result is back
    task automatic wait_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pair_expect_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_interval(input bit [IVL_W-1:0] value);
        wait_results();
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        bit want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                pair_interval = cfg_data;
            if (m_tvalid && m_tready)
            begin
                if (pair_expect_q.size() == 0)
                    report_mismatch("unexpected pair_seen", m_tdata[0], 0);
                else
                begin
                    want = pair_expect_q[0];
                    pair_expect_q.delete(0);
                    if (m_tdata[0] !== want)
                        report_mismatch("pair_seen", m_tdata[0], want);
                    if (m_tdata[OUT_TDATA_W-1:1] !== '0)
                        report_mismatch("zero fill", m_tdata[OUT_TDATA_W-1:1], 0);
                end
            end
            if (s_tvalid && s_tready)
            begin
                want = predict_reverse_pair(s_tdata[TIME_W-1:0],
                                            s_tdata[TIME_W+ADDR_W-1:TIME_W],
                                            s_tdata[TIME_W+2*ADDR_W-1:TIME_W+ADDR_W]);
                pair_expect_q.insert(pair_expect_q.size(), row_known ? row_pair : want);
            end
        end
    end

    // receiver side: random stalls and a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_requests != hold_served)
        begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        bit [TIME_W-1:0]     clock_now;
        bit [TIME_W:0]       next_clock;
        bit [TIME_W-1:0]     stamp;
        bit [63:0]           wide_rand;
        bit [ADDR_W-1:0]     host_pool[6];
        bit [2*ADDR_W-1:0]   recent_flows[$];
        bit [2*ADDR_W-1:0]   flow_key;
        bit [ADDR_W-1:0]     src;
        bit [ADDR_W-1:0]     dst;
        bit [IVL_W-1:0]      ivl;
        int                  item_total;
        int                  step_max;
        int                  pick;

        // same time at interval zero, then eviction on the next tick
        add_row(0, '0, 48'd0, HOST_A, HOST_B, 1, 0);
        add_row(0, '0, 48'd0, HOST_B, HOST_A, 1, 1);
        add_row(0, '0, 48'd1, HOST_B, HOST_A, 0, 0);
        add_row(0, '0, 48'd1, HOST_A, HOST_B, 0, 0);
        // entries aged exactly the interval still match, then go
        add_row(1, 32'd10, '0, '0, '0, 0, 0);
        add_row(0, '0, 48'd100, HOST_X, HOST_Y, 0, 0);
        add_row(0, '0, 48'd105, HOST_Y, HOST_Z, 0, 0);
        add_row(0, '0, 48'd115, HOST_Z, HOST_Y, 0, 0);
        add_row(0, '0, 48'd115, HOST_Z, HOST_Y, 0, 0);
        add_row(0, '0, 48'd116, HOST_Y, HOST_Z, 0, 0);
        add_row(0, '0, 48'd127, HOST_Z, HOST_Y, 0, 0);
        // widest interval, time running backwards, extreme fields
        add_row(1, '1, '0, '0, '0, 0, 0);
        add_row(0, '0, 48'd5000, HOST_A, HOST_B, 0, 0);
        add_row(0, '0, 48'd4000, HOST_B, HOST_A, 0, 0);
        add_row(0, '0, TIME_MAX, ADDR_ONES, '0, 1, 0);
        add_row(0, '0, TIME_MAX, '0, ADDR_ONES, 1, 1);
        add_row(0, '0, 48'd0, ADDR_ONES, '0, 0, 0);
        add_row(1, '0, '0, '0, '0, 0, 0);
        add_row(0, '0, TIME_MAX, '0, ADDR_ONES, 0, 0);

        set_idle_mode(IDLE_BOTH);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probe_table[r])
        begin
            if (probe_table[r].is_cfg)
                write_interval(probe_table[r].interval);
            else
                send_item(probe_table[r].stamp, probe_table[r].src, probe_table[r].dst,
                          probe_table[r].known, probe_table[r].pair);
        end

        clock_now = 48'd200;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    ivl = $urandom_range(40, 1);
                    item_total = 400;
                    step_max = 7;
                    set_idle_mode(IDLE_NONE);
                end
                1:
                begin
                    ivl = '0;
                    item_total = 250;
                    step_max = 3;
                    set_idle_mode(IDLE_SENDER);
                end
                2:
                begin
                    ivl = $urandom_range(200, 20);
                    item_total = 400;
                    step_max = 7;
                    set_idle_mode(IDLE_RECEIVER);
                end
                3:
                begin
                    ivl = '1;
                    item_total = 300;
                    step_max = 7;
                    set_idle_mode(IDLE_BOTH);
                end
                default:
                begin
                    ivl = $urandom;
                    item_total = 275;
                    step_max = 1 << 28;
                    set_idle_mode(IDLE_NONE);
                end
            endcase
            write_interval(ivl);
            foreach (host_pool[h])
                host_pool[h] = $urandom;
            if (p >= 3)
            begin
                host_pool[4] = '1;
                host_pool[5] = '0;
            end
            recent_flows.delete();

            for (int i = 0; i < item_total; i++)
            begin
                if (p == 4 && i % 55 == 0)
                    set_idle_mode(idle_mode_t'((i / 55) % 4));
                if (p == 2 && i == 20)
                    hold_requests <= hold_requests + 1;
                if (p == 0 && i == 200)
                    wait_results();

                // mostly a nondecreasing clock, a few jumps either way
                if ($urandom_range(99) < 3)
                begin
                    wide_rand = {$urandom, $urandom};
                    stamp = wide_rand[TIME_W-1:0];
                    if (stamp > clock_now)
                        clock_now = stamp;
                end
                else
                begin
                    next_clock = clock_now + $urandom_range(step_max);
                    if (next_clock > TIME_MAX)
                        clock_now = TIME_MAX;
                    else
                        clock_now = next_clock[TIME_W-1:0];
                    stamp = clock_now;
                end

                pick = $urandom_range(99);
                if (pick < 40 && recent_flows.size() != 0)
                begin
                    flow_key = recent_flows[$urandom_range(recent_flows.size() - 1)];
                    src = flow_key[ADDR_W-1:0];
                    dst = flow_key[2*ADDR_W-1:ADDR_W];
                end
                else if (pick < 90)
                begin
                    src = host_pool[$urandom_range(5)];
                    dst = host_pool[$urandom_range(5)];
                end
                else
                begin
                    src = $urandom;
                    dst = $urandom;
                end
                recent_flows.insert(recent_flows.size(), {src, dst});
                if (recent_flows.size() > RECENT_KEEP)
                    recent_flows.delete(0);

                send_item(stamp, src, dst, 1'b0, 1'b0);
            end
        end

        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
